@@ sv/equal_area_sphere_to_square_unit_macros.svh @@
// Assertion macros shared by the sphere-to-square pipeline.
// Depends on nothing; included by modules that assert.
`ifndef EQUAL_AREA_SPHERE_TO_SQUARE_UNIT_MACROS_SVH
`define EQUAL_AREA_SPHERE_TO_SQUARE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define EAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define EAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ sv/eas_pkg.sv @@
// Package for the sphere-to-square pipeline: widths and polynomial coefficients.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package eas_pkg;
   localparam int FracBitsDefault = 16;
   localparam int PhiBits = 30;
   localparam int PolyTerms = 7;
   // atan(t)*2/pi coefficients, 30 fraction bits, constant term first
   localparam logic signed [31:0] PolyQ30 [PolyTerms] = '{
      32'sd4368, 32'sd683143051, 32'sd6611245, -32'sd265572574,
      32'sd94679404, 32'sd44993950, -32'sd26992900};
endpackage
`default_nettype wire

@@ sv/eas_stage_ctl.sv @@
// Per-stage valid/stall control for the pipeline: shifts a valid bit chain.
// Depends on eas_pkg (imported) and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "equal_area_sphere_to_square_unit_macros.svh"
module eas_stage_ctl import eas_pkg::*; #(
   parameter int Depth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic             out_stall,
   output logic                  in_stall,
   output logic [Depth-1:0]      adv,
   output logic [Depth-1:0]      vld
);
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;
   logic [Depth:0]   hold;

   // a stage holds when it is full and the stage after it holds
   always_comb begin
      hold[Depth] = out_stall;
      for (int i = Depth-1; i >= 0; i--) hold[i] = vld_ff[i] & hold[i+1];
      for (int i = 0; i < Depth; i++) begin
         adv[i] = !hold[i];
         if (hold[i]) vld_in[i] = vld_ff[i];
         else if (i == 0) vld_in[i] = in_valid;
         else vld_in[i] = vld_ff[i-1];
      end
   end
   assign in_stall = hold[0];
   assign vld = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   `EAS_ASSERT_NEXT(a_hold_last, clock, reset, vld_ff[Depth-1] && out_stall, vld_ff[Depth-1], "last stage dropped while stalled")
   `EAS_ASSERT_IMP(a_stall_full, clock, reset, in_stall, vld_ff[0], "input stalled with empty first stage")
   `EAS_ASSERT_NEXT(a_take, clock, reset, in_valid && !in_stall, vld_ff[0], "accepted transaction lost")
endmodule
`default_nettype wire

@@ sv/equal_area_sphere_to_square_unit.sv @@
// Equal-area sphere-to-square mapping: one direction in, one (u,v) pair out.
// Uses eas_pkg, eas_stage_ctl.
// Channels: req_valid/req_stall with req_dir_x/y/z (signed, FRAC_BITS fraction
// bits); rsp_valid/rsp_stall with rsp_square_u/v (unsigned, clamped to [0,1]).
// A transaction moves when valid is high and stall low.
// Pipeline: one magnitude stage, then FRAC_BITS+1 square-root stages running
// alongside FRAC_BITS+1 division stages (one result bit per stage each), then
// six Horner stages (one multiply each), one scale-multiply stage and one
// output stage: FRAC_BITS+10 register stages (26 at the default).
// rsp_valid is the valid bit of the output stage; one transaction can enter
// every cycle while req_stall is low. Each stage carries a valid
// bit; a full stage holds only while the stage after it also holds, so
// bubbles are squeezed out.
// Reset clears all valid bits; payload registers are not reset.
// When rsp_stall is held, the pipeline fills and then req_stall rises; no
// transaction is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module equal_area_sphere_to_square_unit import eas_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [FRAC_BITS+1:0] req_dir_x,
   input  wire logic signed [FRAC_BITS+1:0] req_dir_y,
   input  wire logic signed [FRAC_BITS+1:0] req_dir_z,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [FRAC_BITS:0]           rsp_square_u,
   output logic [FRAC_BITS:0]           rsp_square_v
);
   localparam int F = FRAC_BITS;
   localparam int NB = F + 1;          // bits of r and t
   localparam int S0 = 1;              // magnitude stage
   localparam int SI = S0 + NB;        // end of iterative stages
   localparam int SH = SI + PolyTerms - 1; // end of Horner
   localparam int Depth = SH + 2;
   localparam int AW = 2*F + 4;        // sqrt radicand / remainder width
   localparam logic [F:0] One = (F+1)'(1) << F;

   logic [Depth-1:0] adv, vld;

   eas_stage_ctl #(.Depth(Depth)) u_ctl (
      .clock(clock), .reset(reset), .in_valid(req_valid), .out_stall(rsp_stall),
      .in_stall(req_stall), .adv(adv), .vld(vld));

   // sideband per stage: signs and swap flag
   logic       sx_ff [Depth], sy_ff [Depth], sz_ff [Depth], sw_ff [Depth];
   // stage 0: magnitudes
   logic [F:0] hi_ff, lo_ff, az_ff;

   function automatic logic [F:0] sat_mag(input logic signed [F+1:0] v);
      logic [F+1:0] m;
      m = v[F+1] ? (F+2)'(-v) : (F+2)'(v);
      return (m > {1'b0, One}) ? One : m[F:0];
   endfunction

   always_ff @(posedge clock) begin
      logic [F:0] ax, ay;
      if (adv[0]) begin
         ax = sat_mag(req_dir_x);
         ay = sat_mag(req_dir_y);
         hi_ff <= (ax > ay) ? ax : ay;
         lo_ff <= (ax > ay) ? ay : ax;
         az_ff <= sat_mag(req_dir_z);
         sx_ff[0] <= req_dir_x[F+1];
         sy_ff[0] <= req_dir_y[F+1];
         sz_ff[0] <= req_dir_z[F+1];
         sw_ff[0] <= ax < ay;
      end
   end

   // carry sideband forward
   always_ff @(posedge clock) begin
      for (int i = 1; i < Depth; i++) if (adv[i]) begin
         sx_ff[i] <= sx_ff[i-1]; sy_ff[i] <= sy_ff[i-1];
         sz_ff[i] <= sz_ff[i-1]; sw_ff[i] <= sw_ff[i-1];
      end
   end

   // square root and division, one result bit per stage
   logic [AW-1:0] rem_ff [NB+1];
   logic [NB-1:0] root_ff [NB+1];
   logic [AW-1:0] rad_ff [NB+1];
   logic [F+1:0]  drem_ff [NB+1];
   logic [NB-1:0] quo_ff [NB+1];
   logic [F:0]    div_ff [NB+1];

   // left-align the radicand so that NB pairs end at bit 2
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign rad_ff[0]  = AW'({1'b0, One} - {1'b0, az_ff}) << (F + AW - 2*NB);
   assign quo_ff[0]  = '0;
   assign div_ff[0]  = hi_ff;

   // lo <= hi so quotient fits NB bits; dividend is lo << F, whose bits above
   // the low NB form the starting remainder lo >> 1
   logic [2*F:0] dvd_ff [NB+1];
   assign drem_ff[0] = {2'b00, lo_ff[F:1]};
   assign dvd_ff[0]  = {lo_ff[0], {(2*F){1'b0}}};

   for (genvar k = 0; k < NB; k++) begin : g_iter
      logic [AW-1:0] rem_n, trial;
      logic [F+1:0]  dr_s;
      always_comb begin
         rem_n = (rem_ff[k] << 2) | AW'(rad_ff[k][AW-1 -: 2]);
         trial = AW'({root_ff[k], 2'b01});
         dr_s  = {drem_ff[k][F:0], dvd_ff[k][2*F]};
      end
      always_ff @(posedge clock) begin
         if (adv[S0+k]) begin
            rad_ff[k+1] <= rad_ff[k] << 2;
            dvd_ff[k+1] <= dvd_ff[k] << 1;
            div_ff[k+1] <= div_ff[k];
            if (rem_n >= trial) begin
               rem_ff[k+1]  <= rem_n - trial;
               root_ff[k+1] <= {root_ff[k][NB-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= rem_n;
               root_ff[k+1] <= {root_ff[k][NB-2:0], 1'b0};
            end
            if (div_ff[k] != '0 && dr_s >= {1'b0, div_ff[k]}) begin
               drem_ff[k+1] <= dr_s - {1'b0, div_ff[k]};
               quo_ff[k+1]  <= {quo_ff[k][NB-2:0], 1'b1};
            end else begin
               drem_ff[k+1] <= dr_s;
               quo_ff[k+1]  <= {quo_ff[k][NB-2:0], 1'b0};
            end
         end
      end
   end
   // radicand holds 2F+1 bits; NB pairs take the top 2F+2 bits of the
   // AW-bit window from the top down

   // Horner chain: acc = rnd(acc*t >> F) + c
   logic signed [33:0] acc_ff [PolyTerms];
   logic [F:0]         r_ff [PolyTerms];
   logic [F:0]         t_ff [PolyTerms];
   assign acc_ff[0] = 34'(PolyQ30[PolyTerms-1]);
   assign r_ff[0]   = root_ff[NB][F:0];
   assign t_ff[0]   = quo_ff[NB][F:0];

   for (genvar k = 0; k < PolyTerms-1; k++) begin : g_horner
      logic signed [34+F+1:0] p;
      logic signed [34+F+1:0] q;
      assign p = acc_ff[k] * $signed({1'b0, t_ff[k]});
      assign q = p + ((F+36)'(1) <<< (F-1));
      always_ff @(posedge clock) begin
         if (adv[SI+k]) begin
            acc_ff[k+1] <= 34'(q >>> F) + 34'(PolyQ30[PolyTerms-2-k]);
            r_ff[k+1]   <= r_ff[k];
            t_ff[k+1]   <= t_ff[k];
         end
      end
   end

   // clamp, reflect, scale by r
   logic signed [33:0] ph;
   logic [PhiBits:0]   phc, phs;
   always_comb begin
      ph = acc_ff[PolyTerms-1];
      if (ph < 0) phc = '0;
      else if (ph > 34'sd1073741824) phc = (PhiBits+1)'(1) << PhiBits;
      else phc = ph[PhiBits:0];
      phs = sw_ff[SH-1] ? ((PhiBits+1)'(1) << PhiBits) - phc : phc;
   end
   logic [PhiBits+F+1:0] vp_ff;
   logic [F:0]           rr_ff;
   always_ff @(posedge clock) begin
      if (adv[SH]) begin
         vp_ff <= phs * r_ff[PolyTerms-1] + ((PhiBits+F+2)'(1) << (PhiBits-1));
         rr_ff <= r_ff[PolyTerms-1];
      end
   end

   // split, mirror, sign, map to [0,1]
   function automatic logic [F:0] to_unit(input logic signed [F+3:0] s);
      logic signed [F+3:0] o;
      o = ($signed({3'b0, One}) + s + $signed((F+4)'(1))) >>> 1;
      if (o < 0) return '0;
      if (o > $signed({3'b0, One})) return One;
      return o[F:0];
   endfunction

   logic [F:0] u_out_ff, v_out_ff;
   always_ff @(posedge clock) begin
      logic signed [F+3:0] v, u, tmp;
      if (adv[SH+1]) begin
         v = $signed({3'b0, vp_ff[PhiBits +: F+1]});
         u = $signed({3'b0, rr_ff}) - v;
         if (sz_ff[SH]) begin
            tmp = u;
            u = $signed({3'b0, One}) - v;
            v = $signed({3'b0, One}) - tmp;
         end
         if (sx_ff[SH]) u = -u;
         if (sy_ff[SH]) v = -v;
         u_out_ff <= to_unit(u);
         v_out_ff <= to_unit(v);
      end
   end

   assign rsp_valid    = vld[Depth-1];
   assign rsp_square_u = u_out_ff;
   assign rsp_square_v = v_out_ff;
endmodule
`default_nettype wire
